@@ sv/length_prefixed_packet_deframer_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on clk_i, masked while rst_ni is low.
`define LPPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check a property on clk_i at every edge, reset included.
`define LPPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPPD_ASSERT(lbl, prop, msg)
`define LPPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ sv/lppd_pkg.sv @@
package lppd_pkg;

  // Length prefix size in bytes, least significant byte first.
  localparam int unsigned HeaderBytesDef = 4;
  // Entries in the queue between the front and back parts.
  localparam int unsigned QueueDepthDef  = 2;

  localparam int unsigned LenW     = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN     = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPORT_ZERO = 1'd1;

  localparam logic [LenW-1:0] MaxLenReset = 32'd65536;

  typedef enum logic [1:0] {
    FUNC_DATA     = 2'd0,
    FUNC_BYP_ON   = 2'd1,
    FUNC_BYP_OFF  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_BYPASS = 2'd1,
    KIND_ZERO   = 2'd2,
    KIND_ABORT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic              first;
    logic              last;
  } result_t;

endpackage

@@ sv/lppd_front.sv @@
`include "length_prefixed_packet_deframer_assert.svh"

module lppd_front #(
  parameter int unsigned HEADER_BYTES = lppd_pkg::HeaderBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [lppd_pkg::ByteW-1:0]   data_byte_i,
  input  logic                         cfg_valid_i,
  input  logic [lppd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lppd_pkg::LenW-1:0]    cfg_data_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output lppd_pkg::result_t            q_data_o
);
  import lppd_pkg::*;

  localparam int unsigned HcW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  logic [LenW-1:0] max_len_q;
  logic            report_zero_q;
  logic [HcW-1:0]  hcnt_q, hcnt_d;
  logic [LenW-1:0] hv_q, hv_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic            rcv_q, rcv_d;
  logic            byp_q, byp_d;
  logic            drop_q, drop_d;

  logic            acc;
  logic            emit;
  result_t         res;
  logic [3:0]      hext;
  logic [LenW-1:0] hv_new;
  logic            pay_last;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign q_push_o   = acc && emit;
  assign q_data_o   = res;

  always_comb begin
    hcnt_d   = hcnt_q;
    hv_d     = hv_q;
    rem_d    = rem_q;
    rcv_d    = rcv_q;
    byp_d    = byp_q;
    drop_d   = drop_q;
    emit     = 1'b0;
    res      = '{kind: KIND_PACKET, data: '0, first: 1'b0, last: 1'b0};
    hext     = 4'(hcnt_q);
    hv_new   = hv_q;
    pay_last = (rem_q == 32'd1);
    // Prefix bytes past the fourth do not touch the length.
    if (hext < 4'd4) begin
      hv_new = hv_q | (LenW'(data_byte_i) << {hext[1:0], 3'b000});
    end
    unique case (func_e'(func_i))
      FUNC_DATA: begin
        if (rem_q == '0) begin
          if (hext == 4'(HEADER_BYTES - 1)) begin
            hcnt_d = '0;
            hv_d   = '0;
            rcv_d  = 1'b0;
            drop_d = (hv_new > max_len_q) && !byp_q;
            rem_d  = hv_new;
            if (hv_new == '0 && report_zero_q) begin
              emit     = 1'b1;
              res.kind = KIND_ZERO;
            end
          end else begin
            hcnt_d = hcnt_q + 1'b1;
            hv_d   = hv_new;
          end
        end else begin
          rem_d     = rem_q - 32'd1;
          rcv_d     = !pay_last;
          res.data  = data_byte_i;
          res.first = !rcv_q;
          res.last  = pay_last;
          if (byp_q) begin
            emit     = 1'b1;
            res.kind = KIND_BYPASS;
            if (pay_last) begin
              byp_d  = 1'b0;
              drop_d = 1'b0;
            end
          end else if (drop_q) begin
            if (pay_last) begin
              drop_d = 1'b0;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      FUNC_BYP_ON: begin
        if (!byp_q) begin
          byp_d = 1'b1;
          if (rem_q != '0) begin
            if (!drop_q && rcv_q) begin
              emit     = 1'b1;
              res.kind = KIND_ABORT;
            end
            drop_d = 1'b0;
            rcv_d  = 1'b0;
          end
        end
      end
      FUNC_BYP_OFF: begin
        if (byp_q) begin
          byp_d = 1'b0;
          if (rem_q != '0) begin
            if (rcv_q) begin
              emit     = 1'b1;
              res.kind = KIND_ABORT;
              drop_d   = 1'b1;
            end else begin
              drop_d = rem_q > max_len_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q     <= MaxLenReset;
      report_zero_q <= 1'b0;
      hcnt_q        <= '0;
      hv_q          <= '0;
      rem_q         <= '0;
      rcv_q         <= 1'b0;
      byp_q         <= 1'b0;
      drop_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_MAX_LEN) begin
          max_len_q <= cfg_data_i;
        end
        if (cfg_index_i == CFG_REPORT_ZERO) begin
          report_zero_q <= cfg_data_i[0];
        end
      end
      if (acc) begin
        hcnt_q <= hcnt_d;
        hv_q   <= hv_d;
        rem_q  <= rem_d;
        rcv_q  <= rcv_d;
        byp_q  <= byp_d;
        drop_q <= drop_d;
      end
    end
  end

  `LPPD_ASSERT(a_byp_excl_drop, !(byp_q && drop_q), "bypass and drop both set")
  `LPPD_ASSERT(a_hdr_no_rcv, (rem_q == '0) |-> !rcv_q, "payload seen in header phase")
  `LPPD_ASSERT(a_hdr_phase, (hcnt_q != '0) |-> (rem_q == '0), "prefix count in payload phase")

endmodule

@@ sv/lppd_fifo.sv @@
`include "length_prefixed_packet_deframer_assert.svh"

module lppd_fifo #(
  parameter int unsigned DEPTH = lppd_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lppd_pkg::result_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lppd_pkg::result_t  pop_data_o
);
  import lppd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  result_t         mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `LPPD_ASSERT(a_cnt_range, cnt_q <= CntW'(DEPTH), "queue count out of range")
  `LPPD_ASSERT(a_no_overflow, !(push_i && full_o), "push into full queue")

endmodule

@@ sv/lppd_back.sv @@
module lppd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  lppd_pkg::result_t          q_data_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 kind_o,
  output logic [lppd_pkg::ByteW-1:0] out_byte_o,
  output logic                       first_o,
  output logic                       last_o
);
  import lppd_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Load whenever the output register is free or being drained.
  assign q_pop_o = !q_empty_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = data_q.kind;
  assign out_byte_o  = data_q.data;
  assign first_o     = data_q.first;
  assign last_o      = data_q.last;

endmodule

@@ sv/length_prefixed_packet_deframer.sv @@
// Deframer for a byte stream of length-prefixed packets.
// Input channel (in_valid_i/in_ready_o): one request per byte or command;
// func_i selects a data byte, bypass on or bypass off.
// Output channel (out_valid_o/out_ready_i): payload bytes with first/last
// marks, bypass bytes, zero-length events and abort events.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 max_packet_len,
// index 1 report_zero; always ready, write only while idle.
// Throughput: one input request per cycle while the result queue is not
// full; the front part updates its prefix/payload counters on each request.
// Path: a result is written into the result queue when its input request
// is accepted, then passes through the output register to the output port.
// Reset: counters, bypass and drop flags clear, max_packet_len returns to
// 65536 and report_zero to 0; no results are pending.
// Receiver stall: results collect in the queue and output register; input
// stays ready until the queue fills, then in_ready_o drops.
module length_prefixed_packet_deframer #(
  parameter int unsigned HEADER_BYTES = lppd_pkg::HeaderBytesDef,
  parameter int unsigned QUEUE_DEPTH  = lppd_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [lppd_pkg::ByteW-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   kind_o,
  output logic [lppd_pkg::ByteW-1:0]   out_byte_o,
  output logic                         first_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lppd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lppd_pkg::LenW-1:0]    cfg_data_i
);
  import lppd_pkg::*;

  logic    q_full, q_empty, q_push, q_pop;
  result_t q_wdata, q_rdata;

  // Registers take every write at once.
  assign cfg_ready_o = 1'b1;

  // Front: decode requests, track prefix/payload state, classify results.
  lppd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Queue: hold results so front and back stall independently.
  lppd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  // Back: advance results into the output register toward the receiver.
  lppd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .first_o     (first_o),
    .last_o      (last_o)
  );

endmodule

@@ test/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lppd_pkg::*;

  // The fourth func code has no meaning; the block must ignore it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Only the low four prefix bytes carry the length.
  localparam int unsigned LEN_BYTES = LenW / ByteW;
  // Cycles to let the block settle before a register write or the verdict.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Cycles to wait for late results once every request is in.
  localparam int unsigned DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]       func;
    logic [ByteW-1:0] data;
  } stream_req_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         func_i = FUNC_DATA;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [ByteW-1:0]   out_byte_o;
  logic               first_o;
  logic               last_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_MAX_LEN;
  logic [LenW-1:0]    cfg_data_i = '0;

  length_prefixed_packet_deframer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .first_o     (first_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting for the stream driver, and the deframed results that
  // the block still owes us, oldest first.
  stream_req_t pending_reqs[$];
  result_t     expected_results[$];

  int unsigned mismatch_count = 0;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          in_accepted = 1'b0;
  bit          cfg_accepted = 1'b0;
  // Idling controls: calm stops new idle bursts of both drivers for the closing stretch.
  bit          calm = 1'b0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  // Shadow of the deframer: prefix assembly, payload counters, mode flags
  // and the two registers, all at their reset values.
  logic [2:0]      hdr_count = '0;
  logic [LenW-1:0] hdr_value = '0;
  logic [LenW-1:0] bytes_left = '0;
  logic [LenW-1:0] bytes_taken = '0;
  logic [LenW-1:0] limit_cfg = MaxLenReset;
  logic            zero_cfg = 1'b0;
  logic            bypass_mode = 1'b0;
  logic            dropping = 1'b0;

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void expect_result(kind_e kind, logic [ByteW-1:0] data, logic first,
                                        logic last);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.first = first;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  // Advance the shadow by one accepted request and queue whatever result
  // it causes.
  function automatic void predict_deframe(logic [1:0] func, logic [ByteW-1:0] data);
    logic is_first;
    logic is_last;
    case (func)
      FUNC_DATA: begin
        if (bytes_left == 0) begin
          // Prefix byte: collect little-endian, ignore anything past the low word.
          if (hdr_count < LEN_BYTES) hdr_value |= LenW'(data) << (8 * hdr_count);
          if (hdr_count + 1 < HeaderBytesDef) begin
            hdr_count++;
          end else begin
            bytes_left  = hdr_value;
            hdr_count   = '0;
            hdr_value   = '0;
            bytes_taken = '0;
            dropping    = (bytes_left > limit_cfg) && !bypass_mode;
            if (bytes_left == 0 && zero_cfg) expect_result(KIND_ZERO, '0, 1'b0, 1'b0);
          end
        end else begin
          is_first = (bytes_taken == 0);
          is_last  = (bytes_left == 1);
          bytes_left--;
          bytes_taken++;
          if (bypass_mode) begin
            // Bypass clears itself at the end of the payload.
            if (is_last) begin
              bypass_mode = 1'b0;
              dropping    = 1'b0;
              bytes_taken = '0;
            end
            expect_result(KIND_BYPASS, data, is_first, is_last);
          end else if (dropping) begin
            if (is_last) begin
              dropping    = 1'b0;
              bytes_taken = '0;
            end
          end else begin
            if (is_last) bytes_taken = '0;
            expect_result(KIND_PACKET, data, is_first, is_last);
          end
        end
      end
      FUNC_BYP_ON: begin
        if (!bypass_mode) begin
          bypass_mode = 1'b1;
          // Mid-packet: abort what was already sent, bypass the rest as a new run.
          if (bytes_left > 0) begin
            if (!dropping && bytes_taken > 0) expect_result(KIND_ABORT, '0, 1'b0, 1'b0);
            dropping    = 1'b0;
            bytes_taken = '0;
          end
        end
      end
      FUNC_BYP_OFF: begin
        if (bypass_mode) begin
          bypass_mode = 1'b0;
          // Mid-run: abort and drop the rest, or fall back to a normal packet
          // if no bypass byte went out yet.
          if (bytes_left > 0) begin
            if (bytes_taken > 0) begin
              expect_result(KIND_ABORT, '0, 1'b0, 1'b0);
              dropping = 1'b1;
            end else begin
              dropping = bytes_left > limit_cfg;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Monitor: check results, track register writes and input requests.
  // Results are checked before new requests are predicted; the block's
  // latency keeps a request's own result out of the same edge anyway.
  always @(posedge clk_i) begin : watch_ports
    result_t want;
    if (!rst_ni) begin
      in_accepted  <= 1'b0;
      cfg_accepted <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d byte %02h first %0b last %0b",
                                    kind_o, out_byte_o, first_o, last_o));
        end else begin
          want = expected_results.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
          if (out_byte_o !== want.data)
            report_mismatch($sformatf("byte %02h, want %02h", out_byte_o, want.data));
          if (first_o !== want.first)
            report_mismatch($sformatf("first %0b, want %0b", first_o, want.first));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MAX_LEN) limit_cfg = cfg_data_i;
        else if (cfg_index_i == CFG_REPORT_ZERO) zero_cfg = cfg_data_i[0];
      end
      if (in_valid_i && in_ready_o) begin
        predict_deframe(func_i, data_byte_i);
        items_accepted++;
      end
      in_accepted  <= in_valid_i && in_ready_o;
      cfg_accepted <= cfg_valid_i && cfg_ready_o;
    end
  end

  // Stream driver: hold a request until it is taken, then either idle for
  // a burst or present the next pending request.
  always @(negedge clk_i) begin : drive_stream
    stream_req_t nxt;
    if (rst_ni && !(in_valid_i && !in_accepted)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && in_idle_on && !calm &&
                   $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        in_valid_i  <= 1'b1;
        func_i      <= nxt.func;
        data_byte_i <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall in random bursts, otherwise stay ready.
  always @(negedge clk_i) begin : drive_ready
    if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (rst_ni && out_idle_on && !calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 18);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void queue_item(logic [1:0] func, logic [ByteW-1:0] data);
    stream_req_t r;
    r.func = func;
    r.data = data;
    pending_reqs.push_back(r);
    items_queued++;
  endfunction

  // Slip a stray command in with probability 1/odds; 0 disables.
  function automatic void insert_command(int unsigned odds);
    if (odds != 0 && $urandom_range(1, odds) == 1) begin
      case ($urandom_range(0, 4))
        0, 1: queue_item(FUNC_BYP_ON, 8'($urandom));
        2, 3: queue_item(FUNC_BYP_OFF, 8'($urandom));
        default: queue_item(FUNC_UNUSED, 8'($urandom));
      endcase
    end
  endfunction

  // Commands never consume stream bytes, so the framing stays aligned.
  function automatic void queue_header(logic [LenW-1:0] len, int unsigned odds);
    for (int i = 0; i < HeaderBytesDef; i++) begin
      insert_command(odds);
      queue_item(FUNC_DATA, 8'(len >> (8 * i)));
    end
  endfunction

  function automatic void queue_packet(logic [LenW-1:0] len, int unsigned odds);
    queue_header(len, odds);
    for (int unsigned i = 0; i < len; i++) begin
      insert_command(odds);
      queue_item(FUNC_DATA, 8'($urandom));
    end
  endfunction

  // Write one register; hold the request until the block takes it.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(negedge clk_i); while (!cfg_accepted);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every request is in and every result is out, then let the
  // block settle. A lost result counts once and is flushed.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    do @(negedge clk_i); while (items_accepted != items_queued);
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One random phase: set both registers, then send well-formed packets
  // with random lengths, random payloads and stray commands mixed in.
  // An open tail leaves a packet whose length can never be reached.
  task automatic run_phase(logic [LenW-1:0] max_len, logic zero_on, int unsigned n_reqs,
                           bit quiet, bit open_tail);
    int unsigned     start_count;
    int unsigned     odds;
    logic [LenW-1:0] len;
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_REPORT_ZERO, LenW'(zero_on));
    @(posedge clk_i);
    calm        = quiet;
    in_idle_on  = ($urandom_range(0, 3) != 0);
    out_idle_on = ($urandom_range(0, 3) != 0);
    odds        = $urandom_range(6, 24);
    start_count = items_queued;
    while (items_queued - start_count < n_reqs) begin
      case ($urandom_range(0, 9))
        0, 1: len = '0;
        7, 8: len = $urandom_range(7, 30);
        // Hug the size limit when it is small enough to reach.
        9: len = (max_len < 30) ? max_len + $urandom_range(0, 1) : $urandom_range(1, 6);
        default: len = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 3) == 0) queue_item(FUNC_BYP_ON, 8'($urandom));
      queue_packet(len, odds);
    end
    if (open_tail) begin
      queue_header('1, 0);
      repeat (6) queue_item(FUNC_DATA, 8'($urandom));
    end
    wait_drained();
  endtask

  initial begin : run_test
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at reset register values.
    @(posedge clk_i);
    queue_item(FUNC_UNUSED, 8'hFF);
    queue_item(FUNC_BYP_OFF, 8'h00);
    // Bypass switched on after a packet byte went out: abort, then bypass run.
    queue_header(2, 0);
    queue_item(FUNC_DATA, 8'h00);
    queue_item(FUNC_BYP_ON, 8'h00);
    queue_item(FUNC_DATA, 8'hFF);
    // Redundant bypass on, then bypass off after a bypass byte: abort, drop rest.
    queue_item(FUNC_BYP_ON, 8'hAA);
    queue_item(FUNC_BYP_ON, 8'h55);
    queue_header(2, 0);
    queue_item(FUNC_DATA, 8'h5A);
    queue_item(FUNC_BYP_OFF, 8'h0F);
    queue_item(FUNC_DATA, 8'h81);
    // Bypass off before any bypass byte: the packet goes through normally.
    queue_item(FUNC_BYP_ON, 8'hF0);
    queue_header(1, 0);
    queue_item(FUNC_BYP_OFF, 8'hC3);
    queue_item(FUNC_DATA, 8'h3C);
    wait_drained();

    // Zero-length report and an oversize packet that must vanish.
    write_reg(CFG_MAX_LEN, 1);
    write_reg(CFG_REPORT_ZERO, 1);
    @(posedge clk_i);
    queue_header(0, 0);
    queue_header(2, 0);
    queue_item(FUNC_DATA, 8'h12);
    queue_item(FUNC_DATA, 8'hED);
    wait_drained();

    run_phase(3, 1'b0, 90, 1'b0, 1'b0);
    run_phase(0, 1'b1, 90, 1'b0, 1'b0);
    run_phase($urandom_range(2, 25), 1'b1, 90, 1'b0, 1'b0);
    run_phase(20, 1'b0, 90, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b0, 90, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 80, 1'b1, 1'b1);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
